FILE: src/mcpi_pkg.sv
// Shared types and constants for the motor current PI controller.
`timescale 1ns / 1ps
package mcpi_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_OPEN  = 3'd1,
    MODE_TEST  = 3'd2,
    MODE_HOLD  = 3'd3,
    MODE_TRACK = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_DUTY     = 3'd1,
    REG_KP       = 3'd2,
    REG_KI       = 3'd3,
    REG_ILIM     = 3'd4,
    REG_PWM      = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_P,
    S_MUL_I,
    S_CLAMP,
    S_MUL_D,
    S_DIV,
    S_OUT
  } state_t;

  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 31;
  localparam int DIV_Q_W = 17;
  localparam int DIV_D_W = 16;

  localparam logic signed [15:0] U_LIMIT = 16'sd25600;
  localparam logic [DIV_D_W-1:0] U_DIVISOR = 16'd25600;
  localparam logic [DIV_D_W-1:0] PCT_DIVISOR = 16'd100;
  localparam logic signed [7:0] PCT_MAX = 8'sd100;
  localparam logic signed [15:0] TEST_REF_INIT = 16'sd200;

endpackage

FILE: src/mcpi_in_if.sv
// Input channel carrying one current sample item.
`timescale 1ns / 1ps
interface mcpi_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] measured_current;
  logic signed [15:0] setpoint_current;
  modport source(output valid, measured_current, setpoint_current, input ready);
  modport sink(input valid, measured_current, setpoint_current, output ready);
endinterface

FILE: src/mcpi_out_if.sv
// Output channel carrying one drive and log item.
`timescale 1ns / 1ps
interface mcpi_out_if;
  logic valid;
  logic ready;
  logic direction;
  logic [16:0] duty_count;
  logic logging;
  logic [6:0] log_index;
  logic signed [15:0] log_reference;
  logic signed [15:0] log_measured;
  logic test_done;
  modport source(output valid, direction, duty_count, logging, log_index, log_reference,
                 log_measured, test_done, input ready);
  modport sink(input valid, direction, duty_count, logging, log_index, log_reference,
               log_measured, test_done, output ready);
endinterface

FILE: src/mcpi_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mcpi_mul
  import mcpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_A_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_A_W-1:0] a_sh;
  logic [MUL_P_W-1:0] b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= a;
        b_sh <= MUL_P_W'(b);
        prod <= '0;
      end else if (busy) begin
        if (a_sh[0]) begin
          prod <= prod + b_sh;
        end
        a_sh <= a_sh >> 1;
        b_sh <= b_sh << 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_A_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/mcpi_div.sv
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module mcpi_div
  import mcpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_Q_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_D_W:0]   rem;
  logic [DIV_Q_W-1:0] n_sh;
  logic [DIV_D_W-1:0] dsr;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  assign trial = {rem[DIV_D_W-1:0], n_sh[DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= (DIV_D_W + 1)'(dividend[DIV_N_W-1:DIV_Q_W]);
        n_sh <= dividend[DIV_Q_W-1:0];
        dsr  <= divisor;
        quot <= '0;
      end else if (busy) begin
        rem  <= fits ? trial - {1'b0, dsr} : trial;
        quot <= {quot[DIV_Q_W-2:0], fits};
        n_sh <= n_sh << 1;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/motor_current_pi_controller_unit.sv
// Top level of the motor current PI controller with APB register port.
// Open-loop items use the bit-serial multiplier once and PI items use it three times;
// both then pass through the bit-serial divider, while idle items skip the arithmetic.
// One item is in work at a time: a new input item is accepted only after the last one
// has been handed to the output register, which waits while the output is not ready.
// Synchronous reset clears control state and restores registers and the test reference.
`timescale 1ns / 1ps
module motor_current_pi_controller_unit
  import mcpi_pkg::*;
#(
  parameter int TEST_POINTS  = 100,
  parameter int TOGGLE_TICKS = 25
) (
  input  logic        clk,
  input  logic        rst,
  mcpi_in_if.sink     in_ch,
  mcpi_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PHASE_W = $clog2(TOGGLE_TICKS + 1);

  logic [2:0]         mode_sel;
  logic signed [7:0]  duty_set;
  logic [15:0]        kp;
  logic [15:0]        ki;
  logic [19:0]        ilim;
  logic [15:0]        pwm_per;

  logic signed [21:0] integrator;
  logic [6:0]         test_counter;
  logic [PHASE_W-1:0] phase;
  logic signed [15:0] test_ref;
  logic               test_finished;

  state_t state, state_next;

  logic signed [15:0] meas_r, ref_r;
  logic [2:0]         mode_r;
  logic               e_neg, acc_neg;
  logic [21:0]        acc_mag;
  logic signed [40:0] u_sum;
  logic               dir_r, zero_r, div_sel;
  logic               log_r, done_r;
  logic [6:0]         lidx_r;
  logic signed [15:0] lref_r, lmeas_r;

  logic               mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic [DIV_Q_W-1:0] div_q;

  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_MODE: prdata = 32'(mode_sel);
      REG_DUTY: prdata = 32'({duty_set});
      REG_KP:   prdata = 32'(kp);
      REG_KI:   prdata = 32'(ki);
      REG_ILIM: prdata = 32'(ilim);
      REG_PWM:  prdata = 32'(pwm_per);
      default:  prdata = '0;
    endcase
  end

  // Evaluation of one tick: effective mode, test reference, error, integrator, duty and output clamps.
  logic [2:0]         mode_eff;
  logic               test_neg;
  logic signed [15:0] tref_use, pi_ref;
  logic signed [16:0] err;
  logic signed [22:0] acc_sum, acc_cl, lim_ext;
  logic signed [7:0]  d_cl;
  logic [6:0]         cnt_inc;
  logic               run_end;
  logic signed [15:0] u_cl;

  always_comb begin
    mode_eff = test_finished ? MODE_IDLE : mode_sel;
    test_neg = (test_counter != 7'd0) && (phase == '0);
    tref_use = test_neg ? -test_ref : test_ref;
    pi_ref   = (mode_r == MODE_TEST) ? tref_use : ref_r;
    err      = 17'(pi_ref) - 17'(meas_r);
    lim_ext  = 23'(ilim);
    acc_sum  = 23'(integrator) + 23'(err);
    if (acc_sum > lim_ext) begin
      acc_cl = lim_ext;
    end else if (acc_sum < -lim_ext) begin
      acc_cl = -lim_ext;
    end else begin
      acc_cl = acc_sum;
    end
    if (duty_set > PCT_MAX) begin
      d_cl = PCT_MAX;
    end else if (duty_set < -PCT_MAX) begin
      d_cl = -PCT_MAX;
    end else begin
      d_cl = duty_set;
    end
    cnt_inc = test_counter + 7'd1;
    run_end = (cnt_inc == 7'(TEST_POINTS)) || (cnt_inc == 7'd0);
    if (u_sum > 41'(U_LIMIT)) begin
      u_cl = U_LIMIT;
    end else if (u_sum < -41'(U_LIMIT)) begin
      u_cl = -U_LIMIT;
    end else begin
      u_cl = 16'(u_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    in_ch.ready = 1'b0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (mode_r)
          MODE_OPEN: begin
            mul_start  = 1'b1;
            mul_a      = MUL_A_W'(pwm_per) + 1'b1;
            mul_b      = MUL_B_W'(d_cl < 0 ? -d_cl : d_cl);
            state_next = S_MUL_D;
          end
          MODE_TEST, MODE_HOLD, MODE_TRACK: begin
            mul_start  = 1'b1;
            mul_a      = MUL_A_W'(kp);
            mul_b      = MUL_B_W'(err < 0 ? -err : err);
            state_next = S_MUL_P;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_MUL_P: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = MUL_A_W'(ki);
          mul_b      = acc_mag;
          state_next = S_MUL_I;
        end
      end
      S_MUL_I: begin
        if (mul_done) begin
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        mul_start  = 1'b1;
        mul_a      = MUL_A_W'(pwm_per);
        mul_b      = MUL_B_W'(u_cl < 0 ? -u_cl : u_cl);
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel      <= MODE_IDLE;
      duty_set      <= '0;
      kp            <= '0;
      ki            <= '0;
      ilim          <= 20'd1000;
      pwm_per       <= 16'd2399;
      integrator    <= '0;
      test_counter  <= '0;
      phase         <= '0;
      test_ref      <= TEST_REF_INIT;
      test_finished <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_MODE: begin
            mode_sel      <= pwdata[2:0];
            test_finished <= 1'b0;
          end
          REG_DUTY: duty_set <= pwdata[7:0];
          REG_KP:   kp <= pwdata[15:0];
          REG_KI:   ki <= pwdata[15:0];
          REG_ILIM: ilim <= pwdata[19:0];
          REG_PWM:  pwm_per <= pwdata[15:0];
          default: ;
        endcase
      end
      if (state == S_EVAL) begin
        if (mode_r == MODE_TEST || mode_r == MODE_HOLD || mode_r == MODE_TRACK) begin
          integrator <= 22'(acc_cl);
        end
        if (mode_r == MODE_TEST) begin
          test_ref <= tref_use;
          if (run_end) begin
            test_counter  <= '0;
            phase         <= '0;
            integrator    <= '0;
            test_finished <= 1'b1;
          end else begin
            test_counter <= cnt_inc;
            phase <= (phase == PHASE_W'(TOGGLE_TICKS - 1)) ? '0 : phase + 1'b1;
          end
        end
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      meas_r <= in_ch.measured_current;
      ref_r  <= in_ch.setpoint_current;
      mode_r <= mode_eff;
    end
    if (state == S_EVAL) begin
      e_neg   <= err < 0;
      acc_neg <= acc_cl < 0;
      acc_mag <= 22'(acc_cl < 0 ? -acc_cl : acc_cl);
      log_r   <= mode_r == MODE_TEST;
      done_r  <= (mode_r == MODE_TEST) && run_end;
      lidx_r  <= (mode_r == MODE_TEST) ? test_counter : 7'd0;
      lref_r  <= (mode_r == MODE_TEST) ? tref_use : 16'sd0;
      lmeas_r <= (mode_r == MODE_TEST) ? meas_r : 16'sd0;
      zero_r  <= !(mode_r == MODE_OPEN || mode_r == MODE_TEST || mode_r == MODE_HOLD ||
                   mode_r == MODE_TRACK);
      div_sel <= mode_r != MODE_OPEN;
      dir_r   <= (mode_r == MODE_OPEN) && (d_cl >= 0);
    end
    if (state == S_MUL_P && mul_done) begin
      u_sum <= e_neg ? -$signed({2'b00, mul_prod}) : $signed({2'b00, mul_prod});
    end
    if (state == S_MUL_I && mul_done) begin
      u_sum <= acc_neg ? u_sum - $signed({2'b00, mul_prod})
                       : u_sum + $signed({2'b00, mul_prod});
    end
    if (state == S_CLAMP) begin
      dir_r <= u_cl > 0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_OUT && (!out_ch.valid || out_ch.ready)) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_ch.valid || out_ch.ready)) begin
      out_ch.direction     <= zero_r ? 1'b0 : dir_r;
      out_ch.duty_count    <= zero_r ? 17'd0 : div_q;
      out_ch.logging       <= log_r;
      out_ch.log_index     <= lidx_r;
      out_ch.log_reference <= lref_r;
      out_ch.log_measured  <= lmeas_r;
      out_ch.test_done     <= done_r;
    end
  end

  mcpi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  mcpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod[DIV_N_W-1:0]),
    .divisor  (div_sel ? U_DIVISOR : PCT_DIVISOR),
    .done     (div_done),
    .quot     (div_q)
  );

  a_finished_cnt: assert property (@(posedge clk) disable iff (rst)
    test_finished |-> test_counter == 7'd0)
    else $error("Test counter not cleared at end of run.");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase < PHASE_W'(TOGGLE_TICKS))
    else $error("Toggle phase out of range.");

  a_done_logs: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.test_done |-> out_ch.logging)
    else $error("Test done item without logging.");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mul_done && !div_done)
    else $error("Arithmetic unit finished while controller idle.");

endmodule
